FILE: design/stb_pkg.sv
// stb_pkg: shared types and constants of the second timer bank
// operation and result codes, slot record layout, step unit result struct
// no dependencies
package stb_pkg;

    localparam int SECS_W    = 9;   // seconds of a slot count, up to 255 + 255
    localparam int FRAC_W    = 4;   // sub-second ticks, enough for 16 per second
    localparam int NEV_W     = 4;   // event counter of one tick
    localparam int EVENT_CAP = 8;   // events reported per tick at most
    localparam int PAUSE_W   = 8;   // pause bits that exist on the port

    typedef enum logic [3:0] {
        FN_TICK   = 4'd0,
        FN_ALLOC  = 4'd1,
        FN_CREATE = 4'd2,
        FN_START  = 4'd3,
        FN_STOP   = 4'd4,
        FN_FREE   = 4'd5,
        FN_SET    = 4'd6,
        FN_GET    = 4'd7,
        FN_FIND   = 4'd8,
        FN_KILL   = 4'd9
    } t_func;

    typedef enum logic [2:0] {
        KD_DONE    = 3'd0,
        KD_EXPIRED = 3'd1,
        KD_WARN    = 3'd2,
        KD_COUNT   = 3'd3,
        KD_GIVEN   = 3'd4,
        KD_NONE    = 3'd5
    } t_kind;

    // slot count is kept as seconds plus sub-second ticks
    typedef struct packed {
        logic [7:0]        owner;
        logic [7:0]        class_flags;
        logic [7:0]        duration;
        logic [7:0]        grace;
        logic [7:0]        warn_mark;
        logic [SECS_W-1:0] secs;
        logic [FRAC_W-1:0] frac;
    } t_rec;

    typedef struct packed {
        logic              rec_we;
        t_rec              rec;
        logic              flag_we;
        logic              in_use;
        logic              running;
        logic              autofree;
        logic              ev_hit;
        logic              finish;
        t_kind             kind;
        logic [SECS_W-1:0] value;
    } t_step;

    function automatic logic is_slot_op(t_func f);
        return (f == FN_START) || (f == FN_STOP) || (f == FN_FREE) ||
               (f == FN_SET) || (f == FN_GET);
    endfunction

    // closing result when a walk ends without an earlier answer
    function automatic t_kind final_kind(t_func f);
        t_kind k;
        k = KD_DONE;
        if ((f == FN_ALLOC) || (f == FN_CREATE) || (f == FN_FIND)) begin
            k = KD_NONE;
        end
        return k;
    endfunction

endpackage

FILE: design/second_timer_bank.sv
// second_timer_bank: top level, sequencer that walks the slot store through
// the shared step unit and an output register; uses stb_pkg, stb_slot_mem,
// stb_step_unit
//
//  channel  direction  handshake           fields
//  input    in         i_valid / o_stall   func slot owner_id duration_secs grace_secs
//                                          warn_secs class_bits new_secs pauses
//  result   out        o_valid / i_stall   kind slot_out value last
//
// one transaction is taken, then the step unit visits one slot per cycle
// tick, alloc, create, find and kill walk up to SLOTS slots: a tick or a kill walks
// all of them, a search stops early when it hits; a slot operation visits its own slot
// the single read port of the slot store sets the pace, one slot each cycle
// a stalled result register holds the walk at the slot that has a result to give
// reset clears all slot flags; the store needs no clearing since no record content
// is used before its slot is allocated
module second_timer_bank #(
    parameter int SLOTS            = 8,
    parameter int TICKS_PER_SECOND = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_func,
    input  logic [2:0] i_slot,
    input  logic [7:0] i_owner_id,
    input  logic [7:0] i_duration_secs,
    input  logic [7:0] i_grace_secs,
    input  logic [7:0] i_warn_secs,
    input  logic [7:0] i_class_bits,
    input  logic [7:0] i_new_secs,
    input  logic       i_global_pause,
    input  logic [7:0] i_slot_pause,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [2:0] o_slot_out,
    output logic [8:0] o_value,
    output logic       o_last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FINAL} t_state;

    t_state                       r_state;
    logic [SLOT_W-1:0]            r_idx;
    logic [stb_pkg::NEV_W-1:0]    r_nev;
    logic [SLOTS-1:0]             r_in_use;
    logic [SLOTS-1:0]             r_running;
    logic [SLOTS-1:0]             r_autofree;
    logic                         r_out_valid;
    stb_pkg::t_kind               r_kind;
    logic [2:0]                   r_slot_out;
    logic [stb_pkg::SECS_W-1:0]   r_value;
    logic                         r_last;

    // latched transaction
    stb_pkg::t_func               r_func;
    logic                         r_slot_ok;
    logic [7:0]                   r_owner_id;
    logic [7:0]                   r_duration;
    logic [7:0]                   r_grace;
    logic [7:0]                   r_warn;
    logic [7:0]                   r_class;
    logic [7:0]                   r_new_secs;
    logic                         r_gpause;
    logic [7:0]                   r_spause;

    stb_pkg::t_func               w_in_func;
    logic                         w_in_range;
    logic [SLOT_W-1:0]            w_start_idx;
    logic                         w_accept;
    logic                         w_is_last;
    logic                         w_held;
    logic                         w_out_free;
    logic                         w_cap_ok;
    logic                         w_want_out;
    logic                         w_advance;
    logic                         w_load_out;
    logic [SLOT_W-1:0]            w_raddr;
    stb_pkg::t_rec                w_rdata;
    stb_pkg::t_step               w_step;
    logic [2:0]                   w_ev_slot;

    assign w_in_func   = stb_pkg::t_func'(i_func);
    assign w_in_range  = (7'(i_slot) < 7'(SLOTS));
    assign w_start_idx = (stb_pkg::is_slot_op(w_in_func) && w_in_range) ?
                         SLOT_W'(i_slot) : '0;
    assign w_accept    = (r_state == S_IDLE) && i_valid;
    assign w_is_last   = (r_idx == LastIdx);
    // pause bits exist only for the first eight slots
    assign w_held      = (7'(r_idx) < 7'(stb_pkg::PAUSE_W)) && r_spause[3'(r_idx)];
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_cap_ok    = (r_nev < stb_pkg::NEV_W'(stb_pkg::EVENT_CAP));
    assign w_want_out  = (w_step.ev_hit && w_cap_ok) || w_step.finish;
    assign w_advance   = (r_state == S_EXEC) && (!w_want_out || w_out_free);
    assign w_load_out  = (w_advance && w_want_out) || ((r_state == S_FINAL) && w_out_free);
    assign w_ev_slot   = ((w_step.kind == stb_pkg::KD_DONE) ||
                          (w_step.kind == stb_pkg::KD_NONE)) ? 3'd0 : 3'(r_idx);

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = w_start_idx;
            S_EXEC:  w_raddr = (w_advance && !w_is_last) ? r_idx + 1'b1 : r_idx;
            default: w_raddr = '0;
        endcase
    end

    stb_slot_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_advance && w_step.rec_we),
        .i_waddr (r_idx),
        .i_wdata (w_step.rec),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    stb_step_unit #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_step (
        .i_func          (r_func),
        .i_rec           (w_rdata),
        .i_in_use        (r_in_use[r_idx]),
        .i_running       (r_running[r_idx]),
        .i_autofree      (r_autofree[r_idx]),
        .i_held          (w_held),
        .i_slot_ok       (r_slot_ok),
        .i_global_pause  (r_gpause),
        .i_owner_id      (r_owner_id),
        .i_duration_secs (r_duration),
        .i_grace_secs    (r_grace),
        .i_warn_secs     (r_warn),
        .i_class_bits    (r_class),
        .i_new_secs      (r_new_secs),
        .o_step          (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func     <= w_in_func;
            r_slot_ok  <= w_in_range && r_in_use[SLOT_W'(i_slot)];
            r_owner_id <= i_owner_id;
            r_duration <= i_duration_secs;
            r_grace    <= i_grace_secs;
            r_warn     <= i_warn_secs;
            r_class    <= i_class_bits;
            r_new_secs <= i_new_secs;
            r_gpause   <= i_global_pause;
            r_spause   <= i_slot_pause;
        end
        if (w_accept) begin
            r_idx <= w_start_idx;
        end else if (w_advance && !w_is_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nev       <= '0;
            r_in_use    <= '0;
            r_running   <= '0;
            r_autofree  <= '0;
            r_out_valid <= 1'b0;
            r_kind      <= stb_pkg::KD_DONE;
            r_slot_out  <= '0;
            r_value     <= '0;
            r_last      <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_nev   <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_advance) begin
                        if (w_step.flag_we) begin
                            r_in_use[r_idx]   <= w_step.in_use;
                            r_running[r_idx]  <= w_step.running;
                            r_autofree[r_idx] <= w_step.autofree;
                        end
                        if (w_want_out) begin
                            r_kind      <= w_step.kind;
                            r_slot_out  <= w_ev_slot;
                            r_value     <= w_step.value;
                            r_last      <= w_step.finish;
                        end
                        if (w_step.ev_hit && w_cap_ok) begin
                            r_nev <= r_nev + 1'b1;
                        end
                        if (w_step.finish) begin
                            r_state <= S_IDLE;
                        end else if (w_is_last) begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                default: begin
                    if (w_out_free) begin
                        r_kind      <= stb_pkg::final_kind(r_func);
                        r_slot_out  <= '0;
                        r_value     <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_slot_out = r_slot_out;
    assign o_value    = r_value;
    assign o_last     = r_last;

    a_run_needs_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_running & ~r_in_use) == '0))
        else $error("running slot that is not in use");

    a_event_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nev <= stb_pkg::NEV_W'(stb_pkg::EVENT_CAP)))
        else $error("tick event count beyond cap");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not start a walk");

    a_no_slot_on_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == stb_pkg::KD_DONE) || (o_kind == stb_pkg::KD_NONE)))
        |-> (o_slot_out == 3'd0))
        else $error("slot reported on a done or none result");

endmodule

FILE: design/stb_slot_mem.sv
// stb_slot_mem: slot record store, one write and one registered read port
// uses stb_pkg::t_rec
module stb_slot_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  stb_pkg::t_rec      i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr,
    output stb_pkg::t_rec      o_rdata
);

    stb_pkg::t_rec r_mem [DEPTH];
    stb_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/stb_step_unit.sv
// stb_step_unit: shared per-slot operation unit of the timer bank
// computes the new record, flags and result for one slot combinationally
// uses stb_pkg types
module stb_step_unit #(
    parameter int TICKS_PER_SECOND = 4
) (
    input  stb_pkg::t_func  i_func,
    input  stb_pkg::t_rec   i_rec,
    input  logic            i_in_use,
    input  logic            i_running,
    input  logic            i_autofree,
    input  logic            i_held,
    input  logic            i_slot_ok,
    input  logic            i_global_pause,
    input  logic [7:0]      i_owner_id,
    input  logic [7:0]      i_duration_secs,
    input  logic [7:0]      i_grace_secs,
    input  logic [7:0]      i_warn_secs,
    input  logic [7:0]      i_class_bits,
    input  logic [7:0]      i_new_secs,
    output stb_pkg::t_step  o_step
);

    localparam logic [stb_pkg::FRAC_W-1:0] FracTop =
        stb_pkg::FRAC_W'(TICKS_PER_SECOND - 1);

    logic                      cnt_nz;
    logic [stb_pkg::SECS_W-1:0] dec_secs;
    logic [stb_pkg::FRAC_W-1:0] dec_frac;
    logic                      dec_zero;
    logic [stb_pkg::SECS_W-1:0] grace_w;
    stb_pkg::t_step            s;

    assign cnt_nz   = (i_rec.secs != '0) || (i_rec.frac != '0);
    assign dec_secs = (i_rec.frac == '0) ? i_rec.secs - 1'b1 : i_rec.secs;
    assign dec_frac = (i_rec.frac == '0) ? FracTop : i_rec.frac - 1'b1;
    assign dec_zero = (dec_secs == '0) && (dec_frac == '0);
    assign grace_w  = stb_pkg::SECS_W'(i_rec.grace);

    always_comb begin
        s          = '0;
        s.rec      = i_rec;
        s.in_use   = i_in_use;
        s.running  = i_running;
        s.autofree = i_autofree;
        s.kind     = stb_pkg::KD_DONE;
        unique case (i_func)
            stb_pkg::FN_TICK: begin
                if (!i_global_pause && cnt_nz && i_running && !i_held) begin
                    s.rec_we   = 1'b1;
                    s.flag_we  = 1'b1;
                    s.rec.secs = dec_secs;
                    s.rec.frac = dec_frac;
                    if (dec_zero) begin
                        s.ev_hit  = 1'b1;
                        s.kind    = stb_pkg::KD_EXPIRED;
                        s.running = 1'b0;
                        if (i_autofree) begin
                            s.in_use = 1'b0;
                        end
                    end else if ((dec_frac == '0) &&
                                 (dec_secs == stb_pkg::SECS_W'(i_rec.warn_mark))) begin
                        s.ev_hit = 1'b1;
                        s.kind   = stb_pkg::KD_WARN;
                    end
                end
            end
            stb_pkg::FN_ALLOC, stb_pkg::FN_CREATE: begin
                if (!i_in_use) begin
                    s.rec_we          = 1'b1;
                    s.flag_we         = 1'b1;
                    s.finish          = 1'b1;
                    s.kind            = stb_pkg::KD_GIVEN;
                    s.rec.owner       = i_owner_id;
                    s.rec.class_flags = i_class_bits;
                    s.rec.duration    = i_duration_secs;
                    s.rec.grace       = i_grace_secs;
                    s.rec.warn_mark   = i_warn_secs;
                    s.rec.frac        = '0;
                    s.in_use          = 1'b1;
                    if (i_func == stb_pkg::FN_CREATE) begin
                        s.rec.secs = stb_pkg::SECS_W'(i_duration_secs) +
                                     stb_pkg::SECS_W'(i_grace_secs);
                        s.running  = 1'b1;
                        s.autofree = 1'b1;
                    end else begin
                        s.rec.secs = '0;
                        s.running  = 1'b0;
                        s.autofree = 1'b0;
                    end
                end
            end
            stb_pkg::FN_FIND: begin
                if (i_in_use && (i_rec.owner == i_owner_id)) begin
                    s.finish = 1'b1;
                    s.kind   = stb_pkg::KD_GIVEN;
                end
            end
            stb_pkg::FN_KILL: begin
                if (i_in_use && ((i_rec.class_flags & i_class_bits) != '0)) begin
                    s.rec_we   = 1'b1;
                    s.flag_we  = 1'b1;
                    s.rec.secs = '0;
                    s.rec.frac = '0;
                    s.in_use   = 1'b0;
                    s.running  = 1'b0;
                end
            end
            stb_pkg::FN_START, stb_pkg::FN_STOP, stb_pkg::FN_FREE,
            stb_pkg::FN_SET, stb_pkg::FN_GET: begin
                s.finish = 1'b1;
                if (!i_slot_ok) begin
                    s.kind = stb_pkg::KD_NONE;
                end else begin
                    unique case (i_func)
                        stb_pkg::FN_START: begin
                            s.rec_we   = 1'b1;
                            s.flag_we  = 1'b1;
                            s.rec.secs = stb_pkg::SECS_W'(i_rec.duration) + grace_w;
                            s.rec.frac = '0;
                            s.running  = 1'b1;
                        end
                        stb_pkg::FN_STOP: begin
                            s.flag_we = 1'b1;
                            s.running = 1'b0;
                        end
                        stb_pkg::FN_FREE: begin
                            s.rec_we   = 1'b1;
                            s.flag_we  = 1'b1;
                            s.rec.secs = '0;
                            s.rec.frac = '0;
                            s.in_use   = 1'b0;
                            s.running  = 1'b0;
                        end
                        stb_pkg::FN_SET: begin
                            s.rec_we   = 1'b1;
                            s.rec.secs = stb_pkg::SECS_W'(i_new_secs) + grace_w;
                            s.rec.frac = '0;
                        end
                        default: begin
                            s.kind  = stb_pkg::KD_COUNT;
                            s.value = (i_rec.secs <= grace_w) ? '0 : i_rec.secs - grace_w;
                        end
                    endcase
                end
            end
            default: begin
                s.finish = 1'b1;
            end
        endcase
    end

    assign o_step = s;

endmodule
